// File: hw/rtl/nssc_pkg.sv
`timescale 1ns / 1ps
// Shared widths, limits and defaults for the nonnegative-sum subarray counter.
package nssc_pkg;

  localparam int VALUE_W   = 32;
  localparam int PREFIX_W  = 48;
  localparam int COUNT_W   = 11;
  localparam int TOTAL_W   = 20;

  localparam int MAX_ITEMS_DEF = 1023;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

endpackage

// File: hw/rtl/nssc_in_if.sv
`timescale 1ns / 1ps
// Request channel carrying one signed element and its start flag.
interface nssc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                start_req;
  logic signed [nssc_pkg::VALUE_W-1:0] value;

  modport source (output valid, output start_req, output value, input ready);
  modport sink   (input valid, input start_req, input value, output ready);
endinterface

// File: hw/rtl/nssc_out_if.sv
`timescale 1ns / 1ps
// Result channel carrying the per-element count, running total and overflow flag.
interface nssc_out_if;
  logic                         valid;
  logic                         ready;
  logic [nssc_pkg::COUNT_W-1:0] count_here;
  logic [nssc_pkg::TOTAL_W-1:0] running_total;
  logic                         overflow;

  modport source (output valid, output count_here, output running_total,
                  output overflow, input ready);
  modport sink   (input valid, input count_here, input running_total,
                  input overflow, output ready);
endinterface

// File: hw/rtl/nonnegative_sum_subarray_counter_core.sv
`timescale 1ns / 1ps
// Top level: counts subarrays with nonnegative sum ending at each element.
//
// Usage:
//   in_ch carries one request per element: value (signed 32 bits) and
//   start_req, which clears the running prefix sum, the prefix store and the
//   running total before the element is taken. out_ch returns one result per
//   request: count_here, running_total and overflow. Both channels move a
//   request when valid and ready are high at a rising edge of clk.
//   One shared 48-bit signed comparator walks the prefix store, one entry per
//   cycle, behind the registered read of the store RAM. An accepted request
//   steps through ST_ZERO (count the implicit zero prefix), ST_SCAN (compare
//   against the stored prefix sums), ST_WRITE (store the new prefix sum and
//   update the total) and ST_OUT (load the output register). A request that
//   finds the store full (MAX_ITEMS entries) is flagged as overflow, left
//   out of the sums, and goes from ST_IDLE straight to ST_OUT.
//   in_ch.ready is high only while the sequencer is idle. The result sits in
//   an output register; a stalled receiver holds it there, and a finished
//   request waits until that register frees up.
//   rst_n (synchronous, active low) clears the prefix sum, the store fill
//   count, the total and the output valid. The store RAM is not cleared:
//   entries are read only after they were written in the current sequence.
module nonnegative_sum_subarray_counter_core #(
  parameter int MAX_ITEMS = nssc_pkg::MAX_ITEMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  nssc_in_if.sink           in_ch,
  nssc_out_if.source        out_ch
);

  localparam int PW   = nssc_pkg::PREFIX_W;
  localparam int VW   = nssc_pkg::VALUE_W;
  localparam int AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW   = $clog2(MAX_ITEMS + 1);
  localparam int NW   = $clog2(MAX_ITEMS + 2);
  localparam int TW   = nssc_pkg::TOTAL_W;
  localparam int OW   = nssc_pkg::COUNT_W;
  localparam int SUMW = ((TW > NW) ? TW : NW) + 1;
  localparam int CMPW = (NW > OW) ? NW : OW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ZERO  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ITEMS);

  logic [2:0]           state_r;
  logic signed [PW-1:0] prefix_sum_r;
  logic signed [PW-1:0] next_r;
  logic [CW-1:0]        store_cnt_r;
  logic [CW-1:0]        addr_r;
  logic                 rd_pend_r;
  logic [NW-1:0]        cnt_r;
  logic [TW-1:0]        total_r;
  logic                 ovf_r;

  logic                 out_valid_r;
  logic [OW-1:0]        out_count_r;
  logic [TW-1:0]        out_total_r;
  logic                 out_ovf_r;

  logic                 accept;
  logic                 rd_en;
  logic                 wr_en;
  logic [PW-1:0]        rd_data;
  logic signed [PW-1:0] base_sum;
  logic signed [PW-1:0] value_ext;
  logic [CW-1:0]        cnt_eff;
  logic                 hit;
  logic [SUMW-1:0]      total_sum;
  logic [TW-1:0]        total_nxt;
  logic [CMPW-1:0]      cnt_wide;
  logic [OW-1:0]        count_sat;
  logic                 out_free;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;

  // Start of a new sequence restarts from an empty store
  assign base_sum  = in_ch.start_req ? '0 : prefix_sum_r;
  assign cnt_eff   = in_ch.start_req ? '0 : store_cnt_r;
  assign value_ext = {{(PW-VW){in_ch.value[VW-1]}}, in_ch.value};

  // Store scan: issue one read per cycle, compare in the next cycle
  assign rd_en = (state_r == ST_SCAN) && (addr_r < store_cnt_r);
  assign hit   = ($signed(rd_data) <= next_r);
  assign wr_en = (state_r == ST_WRITE);

  // Saturating running total
  assign total_sum = SUMW'(total_r) + SUMW'(cnt_r);
  assign total_nxt = (total_sum > SUMW'(nssc_pkg::TOTAL_MAX)) ? nssc_pkg::TOTAL_MAX
                                                            : total_sum[TW-1:0];

  // Saturating per-element count
  assign cnt_wide  = CMPW'(cnt_r);
  assign count_sat = (cnt_wide > CMPW'(nssc_pkg::COUNT_MAX)) ? nssc_pkg::COUNT_MAX
                                                           : cnt_wide[OW-1:0];

  nssc_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (store_cnt_r[AW-1:0]),
    .wdata (next_r),
    .re    (rd_en),
    .raddr (addr_r[AW-1:0]),
    .rdata (rd_data)
  );

  // Sequencer and sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      prefix_sum_r <= '0;
      store_cnt_r  <= '0;
      total_r      <= '0;
      rd_pend_r    <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            store_cnt_r <= cnt_eff;
            if (in_ch.start_req) begin
              prefix_sum_r <= '0;
              total_r      <= '0;
            end
            if (cnt_eff >= FULL_CNT) begin
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_ZERO;
            end
          end
        end
        ST_ZERO: begin
          rd_pend_r <= 1'b0;
          state_r   <= ST_SCAN;
        end
        ST_SCAN: begin
          rd_pend_r <= rd_en;
          if (!rd_en) begin
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          prefix_sum_r <= next_r;
          store_cnt_r  <= store_cnt_r + CW'(1);
          total_r      <= total_nxt;
          state_r      <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Working registers: new prefix sum, scan address and hit count
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          next_r <= base_sum + value_ext;
          ovf_r  <= (cnt_eff >= FULL_CNT);
          cnt_r  <= '0;
        end
      end
      ST_ZERO: begin
        // Count the implicit zero prefix
        cnt_r  <= NW'(!next_r[PW-1]);
        addr_r <= '0;
      end
      ST_SCAN: begin
        if (rd_en) begin
          addr_r <= addr_r + CW'(1);
        end
        if (rd_pend_r && hit) begin
          cnt_r <= cnt_r + NW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load when free, drop on receiver handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && out_free) begin
      out_count_r <= ovf_r ? '0 : count_sat;
      out_total_r <= total_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.count_here    = out_count_r;
  assign out_ch.running_total = out_total_r;
  assign out_ch.overflow      = out_ovf_r;

endmodule

// File: hw/rtl/nssc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module nssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the nonnegative-sum subarray counter core.
module testbench;

  localparam int STORE_DEPTH = nssc_pkg::MAX_ITEMS_DEF;
  localparam int STALL_LIMIT = 6000;
  localparam int RANDOM_ITEMS = 400;

  typedef struct packed {
    logic [nssc_pkg::COUNT_W-1:0] count;
    logic [nssc_pkg::TOTAL_W-1:0] total;
    logic                         ovf;
  } tally_t;

  typedef struct {
    bit          start;
    logic [31:0] value;
    bit          typed;
    int          count;
    int          total;
    bit          ovf;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  nssc_in_if  req_ch ();
  nssc_out_if res_ch ();

  nonnegative_sum_subarray_counter_core #(
    .MAX_ITEMS (STORE_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  // Mirror of the sequence state kept by the core
  logic signed [nssc_pkg::PREFIX_W-1:0] seq_prefix;
  logic signed [nssc_pkg::PREFIX_W-1:0] seq_sums [STORE_DEPTH];
  int                                   seq_fill;
  int                                   seq_total;

  tally_t pending_tallies[$];
  int     mismatches;
  int     results_seen;
  int     quiet_cycles;
  int     src_calm;
  int     sink_calm;
  int     sink_hold;

  // Directed requests: extremes, ties, sign flips and deep prefixes
  plan_row_t opening_plan [23] = '{
    '{1'b0, 32'h0000_0000, 1'b1, 1, 1, 1'b0},
    '{1'b0, 32'h0000_0000, 1'b1, 2, 3, 1'b0},
    '{1'b1, 32'hFFFF_FFFF, 1'b1, 0, 0, 1'b0},
    '{1'b0, 32'h0000_0001, 1'b0, 0, 0, 1'b0},
    '{1'b1, 32'h7FFF_FFFF, 1'b1, 1, 1, 1'b0},
    '{1'b0, 32'h8000_0000, 1'b1, 0, 1, 1'b0},
    '{1'b0, 32'h7FFF_FFFF, 1'b0, 0, 0, 1'b0},
    '{1'b0, 32'h7FFF_FFFF, 1'b0, 0, 0, 1'b0},
    '{1'b0, 32'h7FFF_FFFF, 1'b0, 0, 0, 1'b0},
    '{1'b1, 32'h8000_0000, 1'b1, 0, 0, 1'b0},
    '{1'b0, 32'h8000_0000, 1'b1, 0, 0, 1'b0},
    '{1'b0, 32'h8000_0000, 1'b1, 0, 0, 1'b0},
    '{1'b0, 32'h7FFF_FFFF, 1'b0, 0, 0, 1'b0},
    '{1'b1, 32'h0000_0005, 1'b0, 0, 0, 1'b0},
    '{1'b0, 32'hFFFF_FFFB, 1'b0, 0, 0, 1'b0},
    '{1'b0, 32'h0000_0005, 1'b0, 0, 0, 1'b0},
    '{1'b0, 32'h0000_0000, 1'b0, 0, 0, 1'b0},
    '{1'b0, 32'hFFFF_FFFF, 1'b0, 0, 0, 1'b0},
    '{1'b1, 32'h0000_0000, 1'b0, 0, 0, 1'b0},
    '{1'b0, 32'h0000_0001, 1'b0, 0, 0, 1'b0},
    '{1'b0, 32'hFFFF_FFFE, 1'b0, 0, 0, 1'b0},
    '{1'b0, 32'h5555_5555, 1'b0, 0, 0, 1'b0},
    '{1'b0, 32'hAAAA_AAAA, 1'b0, 0, 0, 1'b0}
  };

  // Free-running clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the mirrored sequence by one element and return its tally
  function automatic tally_t count_nonneg_ending(bit start, logic signed [31:0] elem);
    tally_t                               res;
    logic signed [nssc_pkg::PREFIX_W-1:0] wide;
    logic signed [nssc_pkg::PREFIX_W-1:0] nxt;
    int                                   hits;
    if (start) begin
      seq_prefix = '0;
      seq_fill   = 0;
      seq_total  = 0;
    end
    if (seq_fill >= STORE_DEPTH) begin
      res.count = '0;
      res.total = seq_total[nssc_pkg::TOTAL_W-1:0];
      res.ovf   = 1'b1;
      return res;
    end
    wide = elem;
    nxt  = seq_prefix + wide;
    hits = (nxt >= 0) ? 1 : 0;
    for (int k = 0; k < seq_fill; k++) begin
      if (seq_sums[k] <= nxt) hits++;
    end
    seq_sums[seq_fill] = nxt;
    seq_fill++;
    seq_prefix = nxt;
    seq_total  = (seq_total + hits > int'(nssc_pkg::TOTAL_MAX)) ? int'(nssc_pkg::TOTAL_MAX)
                                                                : seq_total + hits;
    res.count  = (hits > int'(nssc_pkg::COUNT_MAX)) ? nssc_pkg::COUNT_MAX
                                                    : hits[nssc_pkg::COUNT_W-1:0];
    res.total  = seq_total[nssc_pkg::TOTAL_W-1:0];
    res.ovf    = 1'b0;
    return res;
  endfunction

  // Idle length: mostly none or short, a few long, with calm stretches
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 82) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Element mix: small values for ties, mid range, full range, extremes
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 16) - 8;
    if (r < 70) return $urandom_range(0, 2000) - 1000;
    if (r < 90) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  task automatic note_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Drive one request from a falling edge; queue its tally once accepted
  task automatic push_item(bit start, logic [31:0] elem, bit typed, tally_t typed_res);
    int     gap;
    tally_t pred;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) begin
        req_ch.start_req = ($urandom_range(0, 1) == 1);
        req_ch.value     = $urandom;
        @(negedge clk);
      end
    end
    req_ch.valid     = 1'b1;
    req_ch.start_req = start;
    req_ch.value     = elem;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pred = count_nonneg_ending(start, elem);
    pending_tallies.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  // Receiver: hold ready low for random stalls
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      res_ch.ready = 1'b0;
      sink_hold--;
    end else begin
      res_ch.ready = 1'b1;
      if ($urandom_range(0, 3) == 0) sink_hold = pick_gap(sink_calm);
    end
  end

  // Check each result against the oldest pending tally
  always @(posedge clk) begin
    tally_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_tallies.size() == 0) begin
        note_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want = pending_tallies.pop_front();
        if (res_ch.count_here !== want.count)
          note_mismatch($sformatf("result %0d count_here got %0d want %0d",
                                  results_seen, res_ch.count_here, want.count));
        if (res_ch.running_total !== want.total)
          note_mismatch($sformatf("result %0d running_total got %0d want %0d",
                                  results_seen, res_ch.running_total, want.total));
        if (res_ch.overflow !== want.ovf)
          note_mismatch($sformatf("result %0d overflow got %0b want %0b",
                                  results_seen, res_ch.overflow, want.ovf));
      end
      results_seen++;
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tally_t typed_res;
    int     issued;
    int     run_len;
    bit     start;
    req_ch.valid     = 1'b0;
    req_ch.start_req = 1'b0;
    req_ch.value     = '0;
    res_ch.ready     = 1'b0;
    seq_prefix       = '0;
    seq_fill         = 0;
    seq_total        = 0;
    mismatches       = 0;
    results_seen     = 0;
    quiet_cycles     = 0;
    src_calm         = 0;
    sink_calm        = 0;
    sink_hold        = 0;

    // Hold reset, release on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table
    foreach (opening_plan[i]) begin
      typed_res.count = opening_plan[i].count[nssc_pkg::COUNT_W-1:0];
      typed_res.total = opening_plan[i].total[nssc_pkg::TOTAL_W-1:0];
      typed_res.ovf   = opening_plan[i].ovf;
      push_item(opening_plan[i].start, opening_plan[i].value, opening_plan[i].typed,
                typed_res);
    end

    // Random sequences, mostly short, with stray starts mid-run
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      for (int j = 0; j < run_len; j++) begin
        if (j == 0) start = ($urandom_range(0, 9) != 0);
        else        start = ($urandom_range(0, 49) == 0);
        push_item(start, pick_value(), 1'b0, '0);
        issued++;
      end
    end

    // Fill the store to the limit, then hit it with overflow requests
    push_item(1'b1, pick_value(), 1'b0, '0);
    repeat (STORE_DEPTH - 1) push_item(1'b0, pick_value(), 1'b0, '0);
    repeat (3) push_item(1'b0, pick_value(), 1'b0, '0);
    // A start on a full store clears first and is taken normally
    push_item(1'b1, pick_value(), 1'b0, '0);
    repeat (5) push_item(1'b0, pick_value(), 1'b0, '0);
    req_ch.valid = 1'b0;

    // Drain and let the pipeline settle
    while (pending_tallies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: nonnegative_sum_subarray_counter_core.f
hw/rtl/nssc_pkg.sv
hw/rtl/nssc_in_if.sv
hw/rtl/nssc_out_if.sv
hw/rtl/nssc_ram.sv
hw/rtl/nonnegative_sum_subarray_counter_core.sv
bench/testbench.sv
